// ===== rtl/core/seam_pkg.sv =====
package seam_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int ENERGY_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 9;
  localparam int COST_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_CENTER = 2'd1;
  localparam logic [1:0] DIR_RIGHT  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] energy;
    logic        is_final;
    logic [7:0]  query_row;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] seam_cost;
    logic [7:0]  seam_column;
  } result_t;

endpackage

// ===== rtl/core/seam_ram.sv =====
module seam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/seam_path_finder_core.sv =====
// Vertical seam search over an energy map held in on-chip memory. Energy
// values load at one beat per cycle in row-major order while the core is idle
// and its result register is free; the beat marked final starts the search,
// during which no beat is taken. The search walks the map from the bottom row
// up, one pixel per cycle through the energy and cost memories, then traces
// the seam through the direction memory in states TRACE_A and TRACE_B for all
// 256 rows. A row query is answered through the registered read port of the
// seam column memory and then the result register.
module seam_path_finder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  seam_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output seam_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [seam_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [seam_pkg::DIM_W-1:0]     cfg_data
);
  import seam_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SETUP   = 3'd1;
  localparam logic [2:0] S_ROW     = 3'd2;
  localparam logic [2:0] S_TRACE_A = 3'd3;
  localparam logic [2:0] S_TRACE_B = 3'd4;
  localparam logic [2:0] S_QUERY   = 3'd5;

  logic [2:0]             state;
  logic [DIM_W-1:0]       image_width, image_height;
  logic [DIM_W-1:0]       w, h, w_eff, h_eff;
  logic [ADDR_W-1:0]      load_pos, base, tbase;
  logic [ROW_W-1:0]       r, tr;
  logic [DIM_W-1:0]       k, k1;
  logic                   p1, first_row;
  logic [COST_W-1:0]      s_l, s_c, best_cost;
  logic [ENERGY_BITS-1:0] e_hold;
  logic [COL_W-1:0]       best_col, best_col_next, col;

  logic [ENERGY_BITS-1:0] e_rdata;
  logic [COST_W-1:0]      c_rdata;
  logic [1:0]             d_rdata;
  logic [COL_W-1:0]       s_rdata;

  logic                   accept, load_we, proc, row_end, upd, has_l, has_r;
  logic [COL_W-1:0]       c;
  logic [COST_W-1:0]      bv, new_cost;
  logic [1:0]             bd;
  logic [COST_W:0]        sum;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign load_we    = accept && (item.cmd == CMD_LOAD);

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) w_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = image_height;
    if (image_height == '0) h_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
  end

  assign proc    = (state == S_ROW) && p1 && (k1 != '0);
  assign row_end = (state == S_ROW) && p1 && (k1 == w);
  assign c       = COL_W'(k1 - DIM_W'(1));
  assign has_l   = c != '0;
  assign has_r   = k1 < w;

  always_comb begin
    bv = s_c;
    bd = DIR_CENTER;
    if (has_l) begin
      bv = s_l;
      bd = DIR_LEFT;
    end
    if (s_c < bv) begin
      bv = s_c;
      bd = DIR_CENTER;
    end
    if (has_r && (c_rdata < bv)) begin
      bv = c_rdata;
      bd = DIR_RIGHT;
    end
    if (first_row) begin
      bv = '0;
      bd = DIR_CENTER;
    end
    sum      = {1'b0, bv} + (COST_W+1)'(e_hold);
    new_cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
  end

  assign upd           = proc && (r == '0) && ((c == '0) || (new_cost < best_cost));
  assign best_col_next = upd ? c : best_col;

  seam_ram #(.WIDTH(ENERGY_BITS), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_energy (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_pos),
    .wdata (item.energy[ENERGY_BITS-1:0]),
    .raddr (base + ADDR_W'(k)),
    .rdata (e_rdata)
  );

  seam_ram #(.WIDTH(COST_W), .DEPTH(2 * MAX_WIDTH)) u_cost (
    .clk   (clk),
    .we    (proc),
    .waddr ({r[0], c}),
    .wdata (new_cost),
    .raddr ({~r[0], k[COL_W-1:0]}),
    .rdata (c_rdata)
  );

  seam_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_dir (
    .clk   (clk),
    .we    (proc),
    .waddr (base + ADDR_W'(c)),
    .wdata (bd),
    .raddr (tbase + ADDR_W'(col)),
    .rdata (d_rdata)
  );

  seam_ram #(.WIDTH(COL_W), .DEPTH(MAX_HEIGHT)) u_seam (
    .clk   (clk),
    .we    (state == S_TRACE_A),
    .waddr (tr),
    .wdata (col),
    .raddr (item.query_row[ROW_W-1:0]),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
      load_pos     <= '0;
      result_valid <= 1'b0;
      p1           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) image_width <= cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) image_height <= cfg_data;
      end
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.cmd == CMD_QUERY) begin
              state <= S_QUERY;
            end else if (item.is_final) begin
              load_pos <= '0;
              state    <= S_SETUP;
            end else begin
              load_pos <= load_pos + ADDR_W'(1);
            end
          end
        end
        S_SETUP: begin
          state <= S_ROW;
          p1    <= 1'b0;
        end
        S_ROW: begin
          p1 <= (k <= w);
          if (row_end) begin
            p1 <= 1'b0;
            if (r == '0) state <= S_TRACE_A;
          end
        end
        S_TRACE_A: state <= S_TRACE_B;
        S_TRACE_B: begin
          if (tr == ROW_W'(MAX_HEIGHT - 1)) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
          end else begin
            state <= S_TRACE_A;
          end
        end
        S_QUERY: begin
          state        <= S_IDLE;
          result_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SETUP: begin
        w         <= w_eff;
        h         <= h_eff;
        base      <= ADDR_W'(h_eff - DIM_W'(1)) * ADDR_W'(w_eff);
        r         <= ROW_W'(h_eff - DIM_W'(1));
        k         <= '0;
        first_row <= 1'b1;
      end
      S_ROW: begin
        k1 <= k;
        if (k <= w) k <= k + DIM_W'(1);
        if (p1) begin
          s_l    <= s_c;
          s_c    <= c_rdata;
          e_hold <= e_rdata;
        end
        if (upd) begin
          best_cost <= new_cost;
          best_col  <= c;
        end
        if (row_end) begin
          k         <= '0;
          first_row <= 1'b0;
          if (r == '0) begin
            tr    <= '0;
            tbase <= '0;
            col   <= best_col_next;
          end else begin
            r    <= r - ROW_W'(1);
            base <= base - ADDR_W'(w);
          end
        end
      end
      S_TRACE_B: begin
        if (({1'b0, tr} + DIM_W'(1)) < h) begin
          if ((d_rdata == DIR_LEFT) && (col != '0)) begin
            col <= col - COL_W'(1);
          end else if ((d_rdata == DIR_RIGHT) && ((DIM_W'(col) + DIM_W'(1)) < w)) begin
            col <= col + COL_W'(1);
          end
        end
        tbase <= tbase + ADDR_W'(w);
        tr    <= tr + ROW_W'(1);
        if (tr == ROW_W'(MAX_HEIGHT - 1)) begin
          result.result_kind <= KIND_SUMMARY;
          result.seam_cost   <= best_cost;
          result.seam_column <= best_col;
        end
      end
      S_QUERY: begin
        result.result_kind <= KIND_QUERY;
        result.seam_cost   <= '0;
        result.seam_column <= s_rdata;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/seam_checker.sv =====
module seam_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input seam_pkg::item_t                item,
  input logic                           result_valid,
  input logic                           result_ready,
  input seam_pkg::result_t              result
);
  import seam_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_QUERY) |-> result.seam_cost == '0)
    else $error("query beat carries a cost");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat dropped or changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (!result_valid || result_ready))
    else $error("item taken while result register is blocked");

  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.cmd == CMD_QUERY) |=> !item_ready)
    else $error("item taken during query read");

endmodule

bind seam_path_finder_core seam_checker u_seam_checker (.*);

// ===== tb/sv/seam_path_finder_core_tb.sv =====
module seam_path_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import seam_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  seam_path_finder_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  item_t pending_items[$];
  result_t seam_results_due[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic stall_req = 1'b0;
  logic stall_ack = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  logic [DIM_W-1:0] cfg_w = 9'd256;
  logic [DIM_W-1:0] cfg_h = 9'd256;
  logic [15:0] energy_map [0:STORE_DEPTH-1];
  logic [1:0] dir_map [0:STORE_DEPTH-1];
  logic [23:0] cost_row [0:1][0:MAX_WIDTH-1];
  logic [7:0] seam_col [0:MAX_HEIGHT-1];
  logic [ADDR_W-1:0] load_pos = '0;

  int gen_w = 256;
  int gen_h = 256;
  int gen_count = 0;
  bit has_seam = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  task automatic search_seam(output logic [23:0] best_cost, output logic [7:0] best_col);
    int w, h, r, row, c, k, lo, hi, bk, col, a, nb, cb;
    logic [23:0] best;
    logic [1:0] d;
    w = clamp_dim(cfg_w, MAX_WIDTH);
    h = clamp_dim(cfg_h, MAX_HEIGHT);
    for (c = 0; c < w; c++) begin
      a = ((h - 1) * w + c) % STORE_DEPTH;
      cost_row[(h - 1) & 1][c] = sat_add({8'd0, energy_map[a]}, 24'd0);
      dir_map[a] = DIR_CENTER;
    end
    for (r = h - 1; r > 0; r--) begin
      row = r - 1;
      nb = r & 1;
      cb = row & 1;
      for (c = 0; c < w; c++) begin
        lo = (c > 0) ? c - 1 : 0;
        hi = (c + 1 < w) ? c + 1 : c;
        best = cost_row[nb][lo];
        bk = lo;
        a = (row * w + c) % STORE_DEPTH;
        for (k = lo + 1; k <= hi; k++) begin
          if (cost_row[nb][k] < best) begin
            best = cost_row[nb][k];
            bk = k;
          end
        end
        dir_map[a] = 2'(bk + 1 - c);
        cost_row[cb][c] = sat_add({8'd0, energy_map[a]}, best);
      end
    end
    col = 0;
    best = cost_row[0][0];
    for (c = 1; c < w; c++) begin
      if (cost_row[0][c] < best) begin
        best = cost_row[0][c];
        col = c;
      end
    end
    best_cost = best;
    best_col = 8'(col);
    for (r = 0; r < MAX_HEIGHT; r++) begin
      seam_col[r] = 8'(col);
      if (r + 1 < h) begin
        d = dir_map[(r * w + col) % STORE_DEPTH];
        if (d == DIR_LEFT && col > 0) col--;
        else if (d == DIR_RIGHT && col + 1 < w) col++;
      end
    end
  endtask

  task automatic predict_seam(item_t it);
    result_t res;
    logic [23:0] cost;
    logic [7:0] col;
    res = '0;
    if (it.cmd == CMD_QUERY) begin
      res.result_kind = KIND_QUERY;
      res.seam_column = seam_col[it.query_row];
      seam_results_due.push_back(res);
    end else begin
      energy_map[load_pos] = it.energy;
      load_pos = load_pos + 1'b1;
      if (it.is_final) begin
        search_seam(cost, col);
        load_pos = '0;
        res.result_kind = KIND_SUMMARY;
        res.seam_cost = cost;
        res.seam_column = col;
        seam_results_due.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) predict_seam(item);
      if (!item_valid || item_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (seam_results_due.size() == 0) begin
          $display("unexpected result beat: kind %0d cost %0d column %0d",
                   result.result_kind, result.seam_cost, result.seam_column);
          errors++;
        end else begin
          want = seam_results_due.pop_front();
          if (result.result_kind !== want.result_kind)
            report_mismatch("result_kind", result.result_kind, want.result_kind);
          if (result.seam_cost !== want.seam_cost)
            report_mismatch("seam_cost", result.seam_cost, want.seam_cost);
          if (result.seam_column !== want.seam_column)
            report_mismatch("seam_column", result.seam_column, want.seam_column);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (stall_req != stall_ack) begin
        stall_ack <= stall_req;
        stall_left <= 400;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("seam_path_finder_core test failed");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [DIM_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_w = v;
    else cfg_h = v;
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_items.size() > 0 || item_valid || seam_results_due.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dims(int w, int h);
    write_cfg(REG_IMAGE_WIDTH, DIM_W'(w));
    write_cfg(REG_IMAGE_HEIGHT, DIM_W'(h));
    gen_w = clamp_dim(w, MAX_WIDTH);
    gen_h = clamp_dim(h, MAX_HEIGHT);
  endtask

  task automatic push_load(logic [15:0] e, bit fin);
    item_t it;
    it.cmd = CMD_LOAD;
    it.energy = e;
    it.is_final = fin;
    it.query_row = 8'($urandom);
    pending_items.push_back(it);
    gen_count++;
  endtask

  task automatic push_query(logic [7:0] r);
    item_t it;
    it.cmd = CMD_QUERY;
    it.energy = 16'($urandom);
    it.is_final = 1'($urandom);
    it.query_row = r;
    pending_items.push_back(it);
    gen_count++;
  endtask

  task automatic load_frame(int pattern);
    int n, i;
    logic [15:0] e;
    n = gen_w * gen_h;
    for (i = 0; i < n; i++) begin
      case (pattern)
        0: e = 16'($urandom);
        1: e = 16'($urandom_range(3));
        default: e = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      if (has_seam && $urandom_range(99) < 15) push_query(8'($urandom));
      push_load(e, i == n - 1);
    end
    has_seam = 1;
  endtask

  initial begin
    int mode, phase_items, frames, f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_dims(3, 3);
    for (int i = 0; i < 9; i++) push_load(16'd7, i == 8);
    has_seam = 1;
    push_query(8'd0);
    push_query(8'd2);
    push_query(8'd255);
    for (int i = 0; i < 9; i++) push_load((i % 2) ? 16'hFFFF : 16'h0000, i == 8);
    push_query(8'd1);
    drain();
    set_dims(0, 3);
    for (int i = 0; i < 3; i++) push_load(16'(i * 100), i == 2);
    push_query(8'd2);
    drain();
    set_dims(5, 0);
    for (int i = 0; i < 5; i++) push_load(16'(50 - i), i == 4);
    push_query(8'd0);
    drain();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 9; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 9; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      phase_items = gen_count;
      f = 0;
      do begin
        if (mode == 1 && f == 0) set_dims(1, 300);
        else if (mode == 2 && f == 0) set_dims(511, 1);
        else set_dims($urandom_range(9), $urandom_range(9));
        if (mode == 0 && f == 0) stall_req <= ~stall_req;
        frames = (gen_w * gen_h > 100) ? 1 : $urandom_range(6, 3);
        for (int k = 0; k < frames; k++) begin
          load_frame($urandom_range(2));
          for (int q = $urandom_range(3); q > 0; q--) push_query(8'($urandom));
        end
        drain();
        f++;
      end while (gen_count - phase_items < 300);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("seam_path_finder_core test passed");
    end else begin
      $display("seam_path_finder_core test failed");
    end
    $finish;
  end

endmodule
